>>> sv/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants, types and arithmetic helpers of the log factorial unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 24;
  localparam int TABLE_LIMIT_DEF = 10;

  localparam int COUNT_N_W    = 16;
  localparam int LOG_FACT_W   = 44;
  localparam int SUM_FRAC     = 34;
  localparam int CORR_FRAC    = 46;
  localparam int LOG_STEPS    = 58;
  localparam int NL_SHIFT     = 24;
  localparam int HALF_SHIFT   = 25;

  localparam logic [63:0] LN2_Q64        = 64'hB17217F7D1CF79AB;
  localparam logic [63:0] HALF_LN_2PI_Q34 = 64'd15787243789;

  localparam int DIV_QBITS  = CORR_FRAC + 1;
  localparam int DIV_PER    = 4;
  localparam int DIV_STAGES = (DIV_QBITS + DIV_PER - 1) / DIV_PER;
  localparam int MUL_STEPS  = 10;
  localparam int CORR_LAT   = DIV_STAGES + 3 * MUL_STEPS;
  localparam int LN_LAT     = 1 + 2 * LOG_STEPS + 2;
  localparam int LATENCY    = LN_LAT + 5;

  localparam logic [63:0] COEF [9] = '{
    (64'd43867 << CORR_FRAC) / 64'd20349,
    (64'd3617  << CORR_FRAC) / 64'd10200,
    (64'd1     << CORR_FRAC) / 64'd156,
    (64'd691   << CORR_FRAC) / 64'd360360,
    (64'd1     << CORR_FRAC) / 64'd1188,
    (64'd1     << CORR_FRAC) / 64'd1680,
    (64'd1     << CORR_FRAC) / 64'd1260,
    (64'd1     << CORR_FRAC) / 64'd360,
    (64'd1     << CORR_FRAC) / 64'd12
  };

  typedef struct packed {
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } pp_t;

  function automatic pp_t mul_pp(logic [63:0] a, logic [63:0] b);
    pp_t p;
    p.p00 = 64'(a[31:0])  * 64'(b[31:0]);
    p.p01 = 64'(a[31:0])  * 64'(b[63:32]);
    p.p10 = 64'(a[63:32]) * 64'(b[31:0]);
    p.p11 = 64'(a[63:32]) * 64'(b[63:32]);
    return p;
  endfunction

  function automatic logic [127:0] pp_sum(pp_t p);
    return {64'd0, p.p00} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0}
         + {p.p11, 64'd0};
  endfunction

  // elaboration-time log, same steps as the datapath
  function automatic logic [63:0] ln_q58_f(logic [63:0] x);
    logic [5:0]   e;
    logic [63:0]  m;
    logic [63:0]  frac;
    logic [127:0] pr;
    e    = '0;
    frac = '0;
    for (int i = 0; i < 31; i++) begin
      if ((x >> (i + 1)) != 64'd0) e = 6'(i + 1);
    end
    m = x << (62 - e);
    for (int i = 0; i < LOG_STEPS; i++) begin
      pr   = 128'(m) * 128'(m);
      m    = pr[125:62];
      frac = frac << 1;
      if (m[63]) begin
        frac = frac | 64'd1;
        m    = m >> 1;
      end
    end
    pr = 128'((64'(e) << LOG_STEPS) | frac) * 128'(LN2_Q64);
    return pr[127:64];
  endfunction

  function automatic logic [63:0] tab_q34(int k);
    logic [63:0] acc;
    acc = '0;
    for (int j = 2; j <= k; j++) begin
      acc = acc + (ln_q58_f(64'(j)) >> 8);
    end
    return (acc + 64'd32768) >> 16;
  endfunction

endpackage

>>> sv/lfu_ln.sv
// ----------------------------------------------------------------------------
// lfu_ln
// Pipelined natural log, Q6.58: normalize, one squaring per two stages,
// then scale by ln 2.
// ----------------------------------------------------------------------------
module lfu_ln #(
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [COUNT_BITS-1:0] x_i,
  output logic                  valid_o,
  output logic [63:0]           ln_o
);
  import lfu_pkg::*;

  logic        v_q    [LOG_STEPS+1];
  logic [5:0]  e_q    [LOG_STEPS+1];
  logic [63:0] m_q    [LOG_STEPS+1];
  logic [57:0] frac_q [LOG_STEPS+1];

  logic        va_q   [LOG_STEPS];
  logic [5:0]  ea_q   [LOG_STEPS];
  logic [57:0] fa_q   [LOG_STEPS];
  pp_t         pa_q   [LOG_STEPS];

  logic        vc_q, vd_q;
  pp_t         pc_q;
  logic [63:0] ln_q;

  logic [5:0]  e_d;

  always_comb begin
    e_d = '0;
    for (int i = 1; i < COUNT_BITS; i++) begin
      if (x_i[i]) e_d = 6'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q[0]    <= e_d;
    m_q[0]    <= 64'(x_i) << (6'd62 - e_d);
    frac_q[0] <= '0;
  end

  for (genvar s = 0; s < LOG_STEPS; s++) begin : g_sq
    logic [127:0] sq;
    logic [63:0]  m_n;

    assign sq  = pp_sum(pa_q[s]);
    assign m_n = sq[125:62];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q[s]  <= 1'b0;
        v_q[s+1] <= 1'b0;
      end else begin
        va_q[s]  <= v_q[s];
        v_q[s+1] <= va_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      pa_q[s]     <= mul_pp(m_q[s], m_q[s]);
      ea_q[s]     <= e_q[s];
      fa_q[s]     <= frac_q[s];
      e_q[s+1]    <= ea_q[s];
      frac_q[s+1] <= {fa_q[s][56:0], m_n[63]};
      m_q[s+1]    <= m_n[63] ? (m_n >> 1) : m_n;
    end
  end

  logic [127:0] fin;
  assign fin = pp_sum(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      vc_q <= v_q[LOG_STEPS];
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q <= mul_pp({e_q[LOG_STEPS], frac_q[LOG_STEPS]}, LN2_Q64);
    ln_q <= fin[127:64];
  end

  assign valid_o = vd_q;
  assign ln_o    = ln_q;

endmodule

>>> sv/lfu_corr.sv
// ----------------------------------------------------------------------------
// lfu_corr
// Stirling correction h*P(h*h), Q.34: pipelined reciprocal, then a chain of
// three-stage sign-magnitude multiply steps for h squared and Horner's rule.
// ----------------------------------------------------------------------------
module lfu_corr #(
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [COUNT_BITS-1:0] n_i,
  output logic                  valid_o,
  output logic [63:0]           corr_o
);
  import lfu_pkg::*;

  localparam int RW = COUNT_BITS + 1;

  logic                  dv [DIV_STAGES+1];
  logic [COUNT_BITS-1:0] dn [DIV_STAGES+1];
  logic [RW-1:0]         dr [DIV_STAGES+1];
  logic [DIV_QBITS-1:0]  dq [DIV_STAGES+1];

  assign dv[0] = valid_i;
  assign dn[0] = n_i;
  assign dr[0] = '0;
  assign dq[0] = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [RW-1:0]        r_d;
    logic [DIV_QBITS-1:0] q_d;

    always_comb begin
      int idx;
      r_d = dr[s];
      q_d = dq[s];
      for (int b = 0; b < DIV_PER; b++) begin
        idx = DIV_QBITS - 1 - s * DIV_PER - b;
        if (idx >= 0) begin
          r_d = {r_d[RW-2:0], (idx == DIV_QBITS - 1)};
          if (r_d >= {1'b0, dn[s]}) begin
            r_d = r_d - {1'b0, dn[s]};
            q_d = {q_d[DIV_QBITS-2:0], 1'b1};
          end else begin
            q_d = {q_d[DIV_QBITS-2:0], 1'b0};
          end
        end
      end
    end

    logic                  v_q;
    logic [COUNT_BITS-1:0] n_q;
    logic [RW-1:0]         r_q;
    logic [DIV_QBITS-1:0]  q_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= dv[s];
      end
    end

    always_ff @(posedge clk_i) begin
      n_q <= dn[s];
      r_q <= r_d;
      q_q <= q_d;
    end

    assign dv[s+1] = v_q;
    assign dn[s+1] = n_q;
    assign dr[s+1] = r_q;
    assign dq[s+1] = q_q;
  end

  // step 0 forms h*h, steps 1..8 are Horner, the last applies h
  logic        mv [MUL_STEPS+1];
  logic [63:0] ma [MUL_STEPS+1];
  logic [63:0] mh [MUL_STEPS+1];
  logic [63:0] m2 [MUL_STEPS+1];

  assign mv[0] = dv[DIV_STAGES];
  assign ma[0] = 64'(dq[DIV_STAGES]);
  assign mh[0] = 64'(dq[DIV_STAGES]);
  assign m2[0] = '0;

  for (genvar s = 0; s < MUL_STEPS; s++) begin : g_mul
    logic        v1_q, v2_q, v3_q;
    logic        g1_q, g2_q;
    pp_t         p1_q;
    logic [63:0] h1_q, h2_q, h3_q;
    logic [63:0] s1_q, s2_q, s3_q;
    logic [63:0] p2_q, a3_q;
    logic [63:0] mag, opb, sv, a_d, s_d;
    logic [127:0] pr;

    assign mag = ma[s][63] ? (64'd0 - ma[s]) : ma[s];
    assign opb = (s == 0 || s == MUL_STEPS - 1) ? mh[s] : m2[s];
    assign pr  = pp_sum(p1_q);
    assign sv  = g2_q ? (64'd0 - p2_q) : p2_q;

    always_comb begin
      a_d = sv;
      s_d = s2_q;
      if (s == 0) begin
        s_d = p2_q;
        a_d = COEF[0];
      end else if (s == MUL_STEPS - 1) begin
        a_d = sv[63] ? 64'd0 : (sv >> (CORR_FRAC - SUM_FRAC));
      end else if (s % 2 == 1) begin
        a_d = sv - COEF[s % 9];
      end else begin
        a_d = sv + COEF[s % 9];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q <= 1'b0;
        v2_q <= 1'b0;
        v3_q <= 1'b0;
      end else begin
        v1_q <= mv[s];
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
    end

    always_ff @(posedge clk_i) begin
      p1_q <= mul_pp(mag, opb);
      g1_q <= ma[s][63];
      h1_q <= mh[s];
      s1_q <= m2[s];
      p2_q <= pr[CORR_FRAC+63:CORR_FRAC];
      g2_q <= g1_q;
      h2_q <= h1_q;
      s2_q <= s1_q;
      a3_q <= a_d;
      h3_q <= h2_q;
      s3_q <= s_d;
    end

    assign mv[s+1] = v3_q;
    assign ma[s+1] = a3_q;
    assign mh[s+1] = h3_q;
    assign m2[s+1] = s3_q;
  end

  assign valid_o = mv[MUL_STEPS];
  assign corr_o  = ma[MUL_STEPS];

endmodule

>>> sv/log_factorial_unit_core.sv
// ----------------------------------------------------------------------------
// log_factorial_unit_core
// ln(n!) in unsigned fixed point, Stirling series with a small-n table.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive count_n_i and raise start; the word is taken at any edge
//   with start high and busy low. busy stays low, so a new word may enter
//   every cycle and throughput is one word per clock.
//   Output: log_fact_o is shown for one cycle with done_o high, in input
//   order. The result path runs through the log unit: an input register,
//   one normalize stage, 58 squaring steps of two stages each (64-bit
//   square from 32-bit partial products), the ln 2 scaling, then four
//   stages for the sum, table select and rounding. The correction path runs
//   alongside, started later to line up.
//   Reset clears all valid bits; words in flight are dropped.
//   The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module log_factorial_unit_core #(
  parameter int COUNT_BITS  = lfu_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS   = lfu_pkg::FRAC_BITS_DEF,
  parameter int TABLE_LIMIT = lfu_pkg::TABLE_LIMIT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [lfu_pkg::COUNT_N_W-1:0]   count_n_i,
  output logic                            done_o,
  output logic [lfu_pkg::LOG_FACT_W-1:0]  log_fact_o
);
  import lfu_pkg::*;

  localparam int          CORR_DLY = LN_LAT - CORR_LAT;
  localparam int          TIW      = $clog2(TABLE_LIMIT);
  localparam int          RSH      = SUM_FRAC - FRAC_BITS;
  localparam logic [63:0] RND      = 64'd1 << (RSH - 1);
  localparam logic [63:0] TOP      = (64'd1 << LOG_FACT_W) - 64'd1;

  logic                  v0_q;
  logic [COUNT_BITS-1:0] n0_q;
  logic                  vd_q [LN_LAT];
  logic [COUNT_BITS-1:0] nd_q [LN_LAT];

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      for (int i = 0; i < LN_LAT; i++) vd_q[i] <= 1'b0;
    end else begin
      v0_q    <= start && !busy;
      vd_q[0] <= v0_q;
      for (int i = 1; i < LN_LAT; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    n0_q    <= COUNT_BITS'(32'(count_n_i));
    nd_q[0] <= n0_q;
    for (int i = 1; i < LN_LAT; i++) nd_q[i] <= nd_q[i-1];
  end

  logic        ln_v, corr_v;
  logic [63:0] ln_w, corr_w;

  lfu_ln #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .x_i     (n0_q),
    .valid_o (ln_v),
    .ln_o    (ln_w)
  );

  lfu_corr #(
    .COUNT_BITS (COUNT_BITS)
  ) u_corr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vd_q[CORR_DLY-1]),
    .n_i     (nd_q[CORR_DLY-1]),
    .valid_o (corr_v),
    .corr_o  (corr_w)
  );

  logic [63:0] tab_w [TABLE_LIMIT];
  for (genvar k = 0; k < TABLE_LIMIT; k++) begin : g_tab
    assign tab_w[k] = tab_q34(k);
  end

  // sum stages
  logic                  f1_v_q, f2_v_q, f3_v_q, out_v_q;
  logic [COUNT_BITS-1:0] f1_n_q, f2_n_q;
  logic [COUNT_BITS+31:0] f1_pl_q, f1_ph_q;
  logic [63:0]           f1_b_q, f2_s_q, f3_v_q_d;
  logic [LOG_FACT_W-1:0] out_q;
  logic [127:0]          nl;
  logic [63:0]           n_sh, r_d;
  logic                  is_small;

  assign n_sh     = 64'(nd_q[LN_LAT-1]) << SUM_FRAC;
  assign nl       = (128'(f1_ph_q) << 32) + 128'(f1_pl_q);
  assign is_small = 32'(f2_n_q) < 32'(TABLE_LIMIT);
  assign r_d      = (f3_v_q_d + RND) >> RSH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q  <= 1'b0;
      f2_v_q  <= 1'b0;
      f3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      f1_v_q  <= ln_v && corr_v;
      f2_v_q  <= f1_v_q;
      f3_v_q  <= f2_v_q;
      out_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_n_q   <= nd_q[LN_LAT-1];
    f1_pl_q  <= (COUNT_BITS+32)'(nd_q[LN_LAT-1]) * (COUNT_BITS+32)'(ln_w[31:0]);
    f1_ph_q  <= (COUNT_BITS+32)'(nd_q[LN_LAT-1]) * (COUNT_BITS+32)'(ln_w[63:32]);
    f1_b_q   <= HALF_LN_2PI_Q34 + (ln_w >> HALF_SHIFT) + corr_w - n_sh;
    f2_n_q   <= f1_n_q;
    f2_s_q   <= f1_b_q + nl[NL_SHIFT+63:NL_SHIFT];
    f3_v_q_d <= is_small ? tab_w[TIW'(f2_n_q)] : f2_s_q;
    out_q    <= (r_d > TOP) ? TOP[LOG_FACT_W-1:0] : r_d[LOG_FACT_W-1:0];
  end

  assign done_o     = out_v_q;
  assign log_fact_o = out_q;

endmodule

>>> sv/lfu_checker.sv
// ----------------------------------------------------------------------------
// lfu_checker
// Port-level checks of the log factorial unit: fixed latency, no spurious
// results, zero for n of zero or one.
// ----------------------------------------------------------------------------
module lfu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic [lfu_pkg::COUNT_N_W-1:0]   count_n_i,
  input logic                            done_o,
  input logic [lfu_pkg::LOG_FACT_W-1:0]  log_fact_o
);
  import lfu_pkg::*;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("accepted word produced no result");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without accepted word");

  a_trivial : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(count_n_i, LATENCY) == 16'd0 ||
                $past(count_n_i, LATENCY) == 16'd1)) |-> (log_fact_o == '0))
    else $error("ln(0!) or ln(1!) not zero");

endmodule

bind log_factorial_unit_core lfu_checker u_lfu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .count_n_i  (count_n_i),
  .done_o     (done_o),
  .log_fact_o (log_fact_o)
);

>>> tb/tb_log_factorial_unit_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_log_factorial_unit_core
// Regression for the log factorial unit. Counts are sent through the
// start/busy handshake, ln(n!) is predicted in Q.34 and rounded to the output
// format. Each result is checked in order against the queue of expected
// values, across phases of sender idling.
// ----------------------------------------------------------------------------
module tb_log_factorial_unit_core;
  import lfu_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [COUNT_N_W-1:0]  count_n_i;
  logic                  done_o;
  logic [LOG_FACT_W-1:0] log_fact_o;

  logic [COUNT_N_W-1:0]  pending_q[$];
  logic [LOG_FACT_W-1:0] expected_q[$];
  int unsigned           idle_pct;
  int                    err_cnt;
  logic [LOG_FACT_W-1:0] exp_val;

  log_factorial_unit_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .count_n_i(count_n_i), .done_o(done_o), .log_fact_o(log_fact_o)
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // 64x64 product, full 128 bits
  function automatic logic [127:0] wide_mul(logic [63:0] a, logic [63:0] b);
    return 128'(a) * 128'(b);
  endfunction

  // signed a times unsigned b, Q.46, rounded toward zero
  function automatic logic [63:0] corr_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0]  mag;
    logic [127:0] pr;
    mag = a[63] ? -a : a;
    pr  = wide_mul(mag, b) >> CORR_FRAC;
    return a[63] ? -pr[63:0] : pr[63:0];
  endfunction

  function automatic logic [63:0] ln_fixed(logic [63:0] x);
    int unsigned  e;
    logic [63:0]  m;
    logic [63:0]  frac;
    logic [127:0] pr;
    e    = 0;
    frac = '0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = x << (62 - e);
    for (int i = 0; i < 58; i++) begin
      pr   = wide_mul(m, m) >> 62;
      m    = pr[63:0];
      frac = frac << 1;
      if (m[63]) begin
        frac[0] = 1'b1;
        m       = m >> 1;
      end
    end
    pr = wide_mul((64'(e) << 58) | frac, 64'hB17217F7D1CF79AB);
    return pr[127:64];
  endfunction

  function automatic logic [LOG_FACT_W-1:0] log_fact_of(logic [COUNT_N_W-1:0] cnt);
    logic [63:0]  n, v, acc, h, h2, a, c, corr, lnv;
    logic [127:0] pr;
    logic [63:0]  num[9];
    logic [63:0]  den[9];
    num = '{64'd43867, 64'd3617, 64'd1, 64'd691, 64'd1, 64'd1, 64'd1, 64'd1, 64'd1};
    den = '{64'd20349, 64'd10200, 64'd156, 64'd360360, 64'd1188, 64'd1680,
            64'd1260, 64'd360, 64'd12};
    n = 64'(cnt);
    if (n < 10) begin
      acc = '0;
      for (int j = 2; j <= n; j++) acc += ln_fixed(64'(j)) >> 8;
      v = (acc + 64'd32768) >> 16;
    end else begin
      h  = (64'd1 << 46) / n;
      pr = wide_mul(h, h) >> 46;
      h2 = pr[63:0];
      a  = (num[0] << 46) / den[0];
      for (int k = 1; k < 9; k++) begin
        c = (num[k] << 46) / den[k];
        a = corr_mul(a, h2);
        a = (k % 2) ? a - c : a + c;
      end
      corr = corr_mul(a, h);
      corr = corr[63] ? 64'd0 : corr >> 12;
      lnv  = ln_fixed(n);
      v    = 64'd15787243789 + (lnv >> 25);
      pr   = wide_mul(n, lnv) >> 24;
      v    = v + pr[63:0] - (n << 34) + corr;
    end
    v = (v + 64'd512) >> 10;
    if (v > 64'hFFF_FFFF_FFFF) v = 64'hFFF_FFFF_FFFF;
    return v[LOG_FACT_W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start     <= 1'b1;
        count_n_i <= pending_q.pop_front();
      end else begin
        start     <= 1'b0;
        count_n_i <= 16'($urandom);
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) expected_q.push_back(log_fact_of(count_n_i));
      if (done_o) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", log_fact_o));
        end else begin
          exp_val = expected_q.pop_front();
          if (log_fact_o !== exp_val)
            report_mismatch($sformatf("log_fact %h, expected %h", log_fact_o, exp_val));
        end
      end
    end
  end

  initial begin
    int unsigned phase_pct[4];
    phase_pct = '{0, 72, 29, 0};
    err_cnt   = 0;
    idle_pct  = 0;
    rst_ni    = 1'b0;
    start     = 1'b0;
    count_n_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (pending_q[i]) ;
    for (int k = 0; k <= 12; k++) pending_q.push_back(16'(k));
    pending_q.push_back(16'hFFFF);
    pending_q.push_back(16'hFFFE);
    pending_q.push_back(16'h8000);
    pending_q.push_back(16'h7FFF);
    pending_q.push_back(16'h5555);
    pending_q.push_back(16'hAAAA);
    pending_q.push_back(16'd100);
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      for (int i = 0; i < 310; i++) begin
        case ($urandom_range(3))
          0:       pending_q.push_back(16'($urandom_range(15)));
          1:       pending_q.push_back(16'($urandom_range(1000)));
          default: pending_q.push_back(16'($urandom));
        endcase
      end
      while (pending_q.size() > 0 || start) @(posedge clk_i);
    end
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("log_factorial_unit_core regression: pass");
    end else begin
      $display("log_factorial_unit_core regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("log_factorial_unit_core regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
sv/lfu_pkg.sv
sv/lfu_ln.sv
sv/lfu_corr.sv
sv/log_factorial_unit_core.sv
sv/lfu_checker.sv
tb/tb_log_factorial_unit_core.sv
